// ===== hw/rtl/tcm_pkg.sv =====
// shared types and constants of the thermistor comfort monitor
package tcm_pkg;

  localparam int SUM_W   = 16;         // group sum, enough for 64 samples of 1023
  localparam int TEMP_W  = 14;
  localparam int CFG_W   = 20;
  localparam int IDX_W   = 3;
  localparam int FULL_SCALE = 1023;

  localparam logic [29:0] LN2_Q30      = 30'd744261118;
  localparam logic [14:0] KELVIN_25C   = 15'd29815;    // 298.15 k in hundredths
  localparam logic [25:0] SCALE_NUM    = 26'd42933600; // 29815 * 1440
  localparam logic [18:0] OFFSET_MUL   = 19'd367711;
  localparam logic [6:0]  HUNDRED      = 7'd100;
  localparam logic [5:0]  DIV_SCALE    = 6'd50;

  localparam logic signed [TEMP_W-1:0] T_MAX      = 14'sd8191;
  localparam logic signed [TEMP_W-1:0] T_MIN      = -14'sd8192;
  localparam logic signed [TEMP_W-1:0] T_ABS_ZERO = -14'sd7355;

  typedef enum logic [IDX_W-1:0] {
    REG_COMFORT_MAX  = 3'd0,
    REG_COMFORT_MIN  = 3'd1,
    REG_BETA_VALUE   = 3'd2,
    REG_NOMINAL_OHMS = 3'd3,
    REG_SERIES_OHMS  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] comfort_max;
    logic signed [TEMP_W-1:0] comfort_min;
    logic [12:0]              beta_value;
    logic [CFG_W-1:0]         nominal_ohms;
    logic [CFG_W-1:0]         series_ohms;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             fault;
  } work_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic                     blue_led;
    logic                     green_led;
    logic                     red_led;
    logic                     fan_on;
    logic                     sensor_fault;
    logic signed [TEMP_W-1:0] lowest_seen;
    logic signed [TEMP_W-1:0] highest_seen;
    logic [TEMP_W-1:0]        seen_span;
  } res_t;

endpackage

// ===== hw/rtl/thermistor_comfort_monitor.sv =====
// top level of the thermistor comfort monitor
//
// input side is a queue: drive in_adc_sample with in_push high; the sample is
// taken at a clock edge where in_full is low. every SAMPLE_COUNT samples close
// a group, and each group gives one result transaction.
// result side is a queue: while out_empty is low the oldest result is on the
// out_ ports; raise out_pop to take it.
// configuration is written through cfg_wr_en / cfg_index / cfg_data; the
// user must write it only while the block is idle, the block does not enforce
// this; indexes above the register list are ignored. the accumulator adds
// each taken sample; the conversion of a group is run by a single sequencer:
// per log2 operand one shift per leading zero and a final normalize step,
// then 16 squaring steps, then a 14 step divider; a faulted group skips them.
// a two entry queue of group sums lets sampling continue during conversion,
// and a two entry result queue lets the next conversion finish while the
// receiver stalls; in_full is high while the group sum queue is full.
// synchronous reset restores default registers and clears group and tracking state
module thermistor_comfort_monitor #(
  parameter int SAMPLE_COUNT = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  input  logic [9:0]                 in_adc_sample,
  output logic                       in_full,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic signed [13:0]         out_temperature,
  output logic                       out_blue_led,
  output logic                       out_green_led,
  output logic                       out_red_led,
  output logic                       out_fan_on,
  output logic                       out_sensor_fault,
  output logic signed [13:0]         out_lowest_seen,
  output logic signed [13:0]         out_highest_seen,
  output logic [13:0]                out_seen_span,
  input  logic                       cfg_wr_en,
  input  logic [tcm_pkg::IDX_W-1:0]  cfg_index,
  input  logic [tcm_pkg::CFG_W-1:0]  cfg_data
);
  tcm_pkg::cfg_t  cfg_r;
  tcm_pkg::work_t wq_in, wq_out;
  tcm_pkg::res_t  rq_in, rq_out;
  logic           wq_push, wq_full, wq_pop, wq_empty;
  logic           rq_push, rq_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.comfort_max  <= 14'sd1280;
      cfg_r.comfort_min  <= 14'sd1040;
      cfg_r.beta_value   <= 13'd3950;
      cfg_r.nominal_ohms <= 20'd10000;
      cfg_r.series_ohms  <= 20'd10000;
    end else if (cfg_wr_en) begin
      unique case (tcm_pkg::reg_idx_t'(cfg_index))
        tcm_pkg::REG_COMFORT_MAX:  cfg_r.comfort_max  <= $signed(cfg_data[13:0]);
        tcm_pkg::REG_COMFORT_MIN:  cfg_r.comfort_min  <= $signed(cfg_data[13:0]);
        tcm_pkg::REG_BETA_VALUE:   cfg_r.beta_value   <= cfg_data[12:0];
        tcm_pkg::REG_NOMINAL_OHMS: cfg_r.nominal_ohms <= cfg_data;
        tcm_pkg::REG_SERIES_OHMS:  cfg_r.series_ohms  <= cfg_data;
        default: ;
      endcase
    end
  end

  // front end: group accumulation and fault check
  tcm_front #(.SAMPLE_COUNT(SAMPLE_COUNT)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_adc_sample (in_adc_sample),
    .in_full       (in_full),
    .wq_push       (wq_push),
    .wq_data       (wq_in),
    .wq_full       (wq_full)
  );

  // group sums waiting for conversion
  tcm_fifo #(.T(tcm_pkg::work_t), .DEPTH(2)) u_work_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (wq_push),
    .wdata (wq_in),
    .full  (wq_full),
    .pop   (wq_pop),
    .rdata (wq_out),
    .empty (wq_empty)
  );

  // back end: conversion, classification and min/max tracking
  tcm_back #(.SAMPLE_COUNT(SAMPLE_COUNT)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .wq_empty (wq_empty),
    .wq_data  (wq_out),
    .wq_pop   (wq_pop),
    .rq_full  (rq_full),
    .rq_push  (rq_push),
    .rq_data  (rq_in)
  );

  // finished results waiting for the receiver
  tcm_fifo #(.T(tcm_pkg::res_t), .DEPTH(2)) u_result_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rq_push),
    .wdata (rq_in),
    .full  (rq_full),
    .pop   (out_pop),
    .rdata (rq_out),
    .empty (out_empty)
  );

  assign out_temperature  = rq_out.temperature;
  assign out_blue_led     = rq_out.blue_led;
  assign out_green_led    = rq_out.green_led;
  assign out_red_led      = rq_out.red_led;
  assign out_fan_on       = rq_out.fan_on;
  assign out_sensor_fault = rq_out.sensor_fault;
  assign out_lowest_seen  = rq_out.lowest_seen;
  assign out_highest_seen = rq_out.highest_seen;
  assign out_seen_span    = rq_out.seen_span;
endmodule

// ===== hw/rtl/tcm_fifo.sv =====
// small synchronous queue with registered entries
module tcm_fifo #(
  parameter type T = logic,
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  T                 mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end
endmodule

// ===== hw/rtl/tcm_front.sv =====
// sample accumulator: sums each group and flags open or shorted sensor
module tcm_front #(
  parameter int SAMPLE_COUNT = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  input  logic [9:0]     in_adc_sample,
  output logic           in_full,
  output logic           wq_push,
  output tcm_pkg::work_t wq_data,
  input  logic           wq_full
);
  localparam int CNT_W = $clog2(SAMPLE_COUNT + 1);
  localparam logic [tcm_pkg::SUM_W-1:0] TOTAL =
    tcm_pkg::SUM_W'(tcm_pkg::FULL_SCALE * SAMPLE_COUNT);

  logic [CNT_W-1:0]          count_r;
  logic [tcm_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic                      take, last;

  assign in_full = wq_full;
  assign take    = in_push && !wq_full;
  assign sum_nxt = sum_r + tcm_pkg::SUM_W'(in_adc_sample);
  assign last    = (count_r == CNT_W'(SAMPLE_COUNT - 1));

  assign wq_push       = take && last;
  assign wq_data.sum   = sum_nxt;
  assign wq_data.fault = (sum_nxt == '0) || (sum_nxt >= TOTAL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
    end else if (take) begin
      if (last) begin
        count_r <= '0;
        sum_r   <= '0;
      end else begin
        count_r <= count_r + 1'b1;
        sum_r   <= sum_nxt;
      end
    end
  end
endmodule

// ===== hw/rtl/tcm_back.sv =====
// conversion sequencer: log2 unit, beta equation, divider, band check, tracking
module tcm_back #(
  parameter int SAMPLE_COUNT = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tcm_pkg::cfg_t  cfg,
  input  logic           wq_empty,
  input  tcm_pkg::work_t wq_data,
  output logic           wq_pop,
  input  logic           rq_full,
  output logic           rq_push,
  output tcm_pkg::res_t  rq_data
);
  localparam logic [tcm_pkg::SUM_W-1:0] TOTAL =
    tcm_pkg::SUM_W'(tcm_pkg::FULL_SCALE * SAMPLE_COUNT);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_CHK, S_NORM, S_SQR, S_LNA, S_LNB, S_LNC,
    S_DSUM, S_PP0, S_PP1, S_PREP, S_CMP, S_DIV, S_FIN
  } state_t;

  state_t                    state_r;
  logic [tcm_pkg::SUM_W-1:0] sum_r;
  logic                      fault_r;
  logic [35:0]               num_r, den_r, v_r;
  logic [5:0]                e_r;
  logic [30:0]               m_r;
  logic [15:0]               frac_r;
  logic [3:0]                k_r;
  logic                      pass_r;
  logic [21:0]               l2n_r, l2d_r, abs_r, mag_r;
  logic                      neg_r;
  logic signed [37:0]        t1_r;
  logic signed [39:0]        d_r;
  logic [38:0]               p_r;
  logic [57:0]               pp_r;
  logic [43:0]               dv_r;
  logic signed [60:0]        nn_r;
  logic [57:0]               rem_r, sd_r;
  logic [13:0]               q_r;
  logic [3:0]                idx_r;
  logic signed [13:0]        t_r, min_r, max_r;
  logic                      have_first_r;

  // datapath
  logic [61:0]        sq;
  logic [31:0]        sq_hi;
  logic [30:0]        m_nxt;
  logic [15:0]        frac_nxt;
  logic signed [22:0] l2_diff;
  logic [51:0]        ln_prod;
  logic signed [22:0] lq;
  logic signed [37:0] t1_nxt;
  logic [19:0]        b100;
  logic signed [39:0] d_nxt;
  logic [37:0]        pp_hi;
  logic [58:0]        trial;
  logic [13:0]        q_nxt;

  assign sq       = m_r * m_r;
  assign sq_hi    = sq[61:30];
  assign m_nxt    = sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
  assign frac_nxt = {frac_r[14:0], sq_hi[31]};
  assign l2_diff  = $signed({1'b0, l2n_r}) - $signed({1'b0, l2d_r});
  assign ln_prod  = abs_r * tcm_pkg::LN2_Q30;
  assign lq       = neg_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
  assign t1_nxt   = 38'(lq) * $signed({23'b0, tcm_pkg::KELVIN_25C});
  assign b100     = 20'(cfg.beta_value * tcm_pkg::HUNDRED);
  assign d_nxt    = 40'(t1_r) + $signed({4'b0, b100, 16'b0});
  assign pp_hi    = d_r[38:20] * tcm_pkg::OFFSET_MUL;
  assign trial    = {1'b0, rem_r} - {1'b0, sd_r};
  assign q_nxt    = {q_r[12:0], ~trial[58]};

  // result of the finished conversion
  logic               ok_band, cold, hot;
  logic signed [13:0] min_nxt, max_nxt;
  logic               first_nxt;

  assign ok_band = (t_r > cfg.comfort_min) && (t_r < cfg.comfort_max);
  assign cold    = (t_r < cfg.comfort_min);
  assign hot     = (t_r > cfg.comfort_max);

  always_comb begin
    min_nxt   = min_r;
    max_nxt   = max_r;
    first_nxt = have_first_r;
    if (!fault_r) begin
      first_nxt = 1'b1;
      if (!have_first_r) begin
        min_nxt = t_r;
        max_nxt = t_r;
      end else if (max_r < t_r) begin
        max_nxt = t_r;
      end else if (min_r > t_r) begin
        min_nxt = t_r;
      end
    end
  end

  always_comb begin
    rq_data.temperature  = t_r;
    rq_data.sensor_fault = fault_r;
    rq_data.lowest_seen  = min_nxt;
    rq_data.highest_seen = max_nxt;
    rq_data.seen_span    = 14'(max_nxt - min_nxt);
    if (fault_r || !(ok_band || cold || hot)) begin
      rq_data.blue_led  = 1'b1;
      rq_data.green_led = 1'b1;
      rq_data.red_led   = 1'b1;
      rq_data.fan_on    = 1'b0;
    end else begin
      rq_data.blue_led  = !ok_band && cold;
      rq_data.green_led = ok_band;
      rq_data.red_led   = !ok_band && !cold && hot;
      rq_data.fan_on    = !ok_band;
    end
  end

  assign wq_pop  = (state_r == S_IDLE) && !wq_empty;
  assign rq_push = (state_r == S_FIN) && !rq_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      min_r        <= '0;
      max_r        <= '0;
      have_first_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (!wq_empty) begin
            sum_r   <= wq_data.sum;
            fault_r <= wq_data.fault;
            t_r     <= tcm_pkg::T_MIN;
            state_r <= wq_data.fault ? S_FIN : S_MUL;
          end
        end
        S_MUL: begin
          num_r   <= 36'(cfg.series_ohms * sum_r);
          den_r   <= 36'(cfg.nominal_ohms * (TOTAL - sum_r));
          state_r <= S_CHK;
        end
        S_CHK: begin
          pass_r <= 1'b0;
          v_r    <= num_r;
          e_r    <= 6'd35;
          if (num_r == '0) begin
            t_r     <= tcm_pkg::T_MAX;
            state_r <= S_FIN;
          end else if (den_r == '0) begin
            t_r     <= tcm_pkg::T_ABS_ZERO;
            state_r <= S_FIN;
          end else begin
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          if (v_r[35]) begin
            m_r     <= v_r[35:5];
            frac_r  <= '0;
            k_r     <= '0;
            state_r <= S_SQR;
          end else begin
            v_r <= {v_r[34:0], 1'b0};
            e_r <= e_r - 1'b1;
          end
        end
        S_SQR: begin
          m_r    <= m_nxt;
          frac_r <= frac_nxt;
          k_r    <= k_r + 1'b1;
          if (k_r == 4'd15) begin
            if (!pass_r) begin
              l2n_r   <= {e_r, frac_nxt};
              pass_r  <= 1'b1;
              v_r     <= den_r;
              e_r     <= 6'd35;
              state_r <= S_NORM;
            end else begin
              l2d_r   <= {e_r, frac_nxt};
              state_r <= S_LNA;
            end
          end
        end
        S_LNA: begin
          neg_r   <= l2_diff[22];
          abs_r   <= l2_diff[22] ? 22'(-l2_diff) : l2_diff[21:0];
          state_r <= S_LNB;
        end
        S_LNB: begin
          mag_r   <= ln_prod[51:30];
          state_r <= S_LNC;
        end
        S_LNC: begin
          t1_r    <= t1_nxt;
          state_r <= S_DSUM;
        end
        S_DSUM: begin
          d_r     <= d_nxt;
          p_r     <= 39'(cfg.beta_value * tcm_pkg::SCALE_NUM);
          state_r <= S_PP0;
        end
        S_PP0: begin
          if (d_r <= 0) begin
            t_r     <= tcm_pkg::T_MAX;
            state_r <= S_FIN;
          end else begin
            pp_r    <= 58'(d_r[19:0] * tcm_pkg::OFFSET_MUL);
            dv_r    <= 44'(d_r[38:0] * tcm_pkg::DIV_SCALE);
            state_r <= S_PP1;
          end
        end
        S_PP1: begin
          pp_r    <= pp_r + {pp_hi, 20'b0};
          state_r <= S_PREP;
        end
        S_PREP: begin
          // offset by 8192 divisors so the quotient is never negative
          nn_r    <= $signed({6'b0, p_r, 16'b0}) - $signed({3'b0, pp_r})
                     + $signed({4'b0, dv_r, 13'b0});
          state_r <= S_CMP;
        end
        S_CMP: begin
          rem_r <= nn_r[57:0];
          sd_r  <= {1'b0, dv_r, 13'b0};
          q_r   <= '0;
          idx_r <= 4'd13;
          if (nn_r < 0) begin
            t_r     <= tcm_pkg::T_MIN;
            state_r <= S_FIN;
          end else if (nn_r[59:0] >= {2'b0, dv_r, 14'b0}) begin
            t_r     <= tcm_pkg::T_MAX;
            state_r <= S_FIN;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (!trial[58]) begin
            rem_r <= trial[57:0];
          end
          sd_r  <= {1'b0, sd_r[57:1]};
          q_r   <= q_nxt;
          idx_r <= idx_r - 1'b1;
          if (idx_r == '0) begin
            t_r     <= $signed({~q_nxt[13], q_nxt[12:0]});
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!rq_full) begin
            min_r        <= min_nxt;
            max_r        <= max_nxt;
            have_first_r <= first_nxt;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== verif/tb_top.sv =====
// testbench of the thermistor comfort monitor with a built-in temperature predictor
`timescale 1ns / 100ps

module tb_top;

  localparam int SAMPLES = 10;
  localparam int GROUP_TOTAL = tcm_pkg::FULL_SCALE * SAMPLES;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic [9:0] in_adc_sample = '0;
  logic in_full;
  logic out_empty;
  logic out_pop = 1'b0;
  logic signed [13:0] out_temperature;
  logic out_blue_led, out_green_led, out_red_led, out_fan_on, out_sensor_fault;
  logic signed [13:0] out_lowest_seen, out_highest_seen;
  logic [13:0] out_seen_span;
  logic cfg_wr_en = 1'b0;
  logic [tcm_pkg::IDX_W-1:0] cfg_index = '0;
  logic [tcm_pkg::CFG_W-1:0] cfg_data = '0;

  thermistor_comfort_monitor #(.SAMPLE_COUNT(SAMPLES)) uut (.*);

  // free-running clock, 4 ns period
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // predictor copy of configuration and tracking state
  int          band_hi, band_lo;
  int unsigned beta_k, nom_ohms, ser_ohms;
  int unsigned acc_count, acc_sum;
  int          track_lo, track_hi;
  bit          track_valid;

  logic [9:0]     pending_samples[$];
  tcm_pkg::res_t  expected_readings[$];
  int             error_count = 0;
  bit             quiet = 1'b0;

  // log2 in q16: normalize to q30 in [1,2), then 16 squaring steps
  function automatic longint log2_fix(longint unsigned v);
    int e;
    longint unsigned t, m;
    longint frac;
    e = 0;
    t = v;
    frac = 0;
    while (t > 1) begin
      t >>= 1;
      e++;
    end
    m = (e > 30) ? (v >> (e - 30)) : (v << (30 - e));
    for (int k = 0; k < 16; k++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m >>= 1;
        frac |= 1;
      end
    end
    return longint'(e) * 65536 + frac;
  endfunction

  // group sum to temperature in 1/16 F, saturated to 14 bits
  function automatic int sum_to_temp(int unsigned s);
    longint unsigned num, den;
    longint l2, mag, lq, d, n, x, dd, q;
    num = longint'(ser_ohms) * s;
    den = longint'(nom_ohms) * (GROUP_TOTAL - s);
    if (num == 0) return 8191;
    if (den == 0) return -7355;
    l2 = log2_fix(num) - log2_fix(den);
    mag = (l2 < 0 ? -l2 : l2) * 744261118 / (64'sd1 <<< 30);
    lq = l2 < 0 ? -mag : mag;
    d = 29815 * lq + 100 * longint'(beta_k) * 65536;
    if (d <= 0) return 8191;
    n = longint'(beta_k) * 29815 * 65536;
    x = 2880 * n - 735472 * d;
    dd = 100 * d;
    x = 2 * x + dd;
    dd = 2 * dd;
    q = x / dd;
    if (x % dd != 0 && x < 0) q--;
    if (q > 8191) return 8191;
    if (q < -8192) return -8192;
    return int'(q);
  endfunction

  // accumulate one accepted sample; a closed group queues one expected reading
  task automatic predict_sample(logic [9:0] smp);
    tcm_pkg::res_t r;
    int t;
    int unsigned s;
    acc_sum += smp;
    acc_count++;
    if (acc_count < SAMPLES) return;
    s = acc_sum;
    acc_sum = 0;
    acc_count = 0;
    r = '0;
    if (s == 0 || s >= GROUP_TOTAL) begin
      t = -8192;
      r.sensor_fault = 1'b1;
      {r.blue_led, r.green_led, r.red_led, r.fan_on} = 4'b1110;
    end else begin
      t = sum_to_temp(s);
      // band is tested first, then cold, then hot; a reading on a band edge lights all leds with the fan off
      if (t > band_lo && t < band_hi) {r.blue_led, r.green_led, r.red_led, r.fan_on} = 4'b0100;
      else if (t < band_lo) {r.blue_led, r.green_led, r.red_led, r.fan_on} = 4'b1001;
      else if (t > band_hi) {r.blue_led, r.green_led, r.red_led, r.fan_on} = 4'b0011;
      else {r.blue_led, r.green_led, r.red_led, r.fan_on} = 4'b1110;
      if (!track_valid) begin
        track_lo = t;
        track_hi = t;
        track_valid = 1'b1;
      end else if (track_hi < t) track_hi = t;
      else if (track_lo > t) track_lo = t;
    end
    r.temperature = t[13:0];
    r.lowest_seen = track_lo[13:0];
    r.highest_seen = track_hi[13:0];
    r.seen_span = 14'(track_hi - track_lo);
    expected_readings.push_back(r);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // driver: feeds pending samples, holds a transaction while in_full is high
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) predict_sample(in_adc_sample);
      if (in_push && in_full) begin
        // keep the same transaction on the port
      end else if (in_gap > 0) begin
        in_gap--;
        in_push <= 1'b0;
      end else if (pending_samples.size() > 0 && !quiet && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(1, 15) - 1;
        in_push <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        in_push <= 1'b1;
        in_adc_sample <= pending_samples.pop_front();
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // monitor: checks each popped reading against the oldest expectation
  int out_gap = 0;
  always @(posedge clk) begin
    tcm_pkg::res_t w;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("unexpected reading", out_temperature, 0);
        end else begin
          w = expected_readings.pop_front();
          if (out_temperature !== w.temperature)
            report_mismatch("temperature", out_temperature, w.temperature);
          if (out_blue_led !== w.blue_led) report_mismatch("blue_led", out_blue_led, w.blue_led);
          if (out_green_led !== w.green_led)
            report_mismatch("green_led", out_green_led, w.green_led);
          if (out_red_led !== w.red_led) report_mismatch("red_led", out_red_led, w.red_led);
          if (out_fan_on !== w.fan_on) report_mismatch("fan_on", out_fan_on, w.fan_on);
          if (out_sensor_fault !== w.sensor_fault)
            report_mismatch("sensor_fault", out_sensor_fault, w.sensor_fault);
          if (out_lowest_seen !== w.lowest_seen)
            report_mismatch("lowest_seen", out_lowest_seen, w.lowest_seen);
          if (out_highest_seen !== w.highest_seen)
            report_mismatch("highest_seen", out_highest_seen, w.highest_seen);
          if (out_seen_span !== w.seen_span)
            report_mismatch("seen_span", out_seen_span, w.seen_span);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(1, 15) - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // one group of samples around a level, clamped to the 10-bit range
  task automatic add_group(int level, int spread);
    int v;
    for (int i = 0; i < SAMPLES; i++) begin
      v = level + $urandom_range(0, 2 * spread) - spread;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      pending_samples.push_back(v[9:0]);
    end
  endtask

  // wait until every queued sample went in and every reading came out
  task automatic drain();
    while (pending_samples.size() != 0 || in_push || expected_readings.size() != 0)
      @(posedge clk);
    // a tail of samples that does not fill a group gives no reading and is not waited for
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [tcm_pkg::IDX_W-1:0] idx, logic [tcm_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      tcm_pkg::REG_COMFORT_MAX: band_hi = int'(signed'(val[13:0]));
      tcm_pkg::REG_COMFORT_MIN: band_lo = int'(signed'(val[13:0]));
      tcm_pkg::REG_BETA_VALUE: beta_k = val[12:0];
      tcm_pkg::REG_NOMINAL_OHMS: nom_ohms = val;
      tcm_pkg::REG_SERIES_OHMS: ser_ohms = val;
      default: ;
    endcase
  endtask

  task automatic set_config(int hi, int lo, int beta, int nom, int ser);
    logic [31:0] h, l;
    h = hi;
    l = lo;
    write_reg(tcm_pkg::REG_COMFORT_MAX, tcm_pkg::CFG_W'(h[13:0]));
    write_reg(tcm_pkg::REG_COMFORT_MIN, tcm_pkg::CFG_W'(l[13:0]));
    write_reg(tcm_pkg::REG_BETA_VALUE, tcm_pkg::CFG_W'(beta));
    write_reg(tcm_pkg::REG_NOMINAL_OHMS, tcm_pkg::CFG_W'(nom));
    write_reg(tcm_pkg::REG_SERIES_OHMS, tcm_pkg::CFG_W'(ser));
    // out-of-range index must be ignored
    write_reg(tcm_pkg::IDX_W'($urandom_range(5, 7)),
              $urandom_range(0, 1) ? 20'hFFFFF : tcm_pkg::CFG_W'($urandom));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // random groups: mostly narrow levels to sweep the bands, some pure noise, some at the rails
  task automatic random_groups(int n);
    for (int g = 0; g < n; g++) begin
      case ($urandom_range(0, 5))
        0: add_group($urandom_range(0, 1023), 512);
        1: add_group($urandom_range(0, 1) ? 0 : 1023, 1);
        default: add_group($urandom_range(1, 1022), $urandom_range(0, 8));
      endcase
    end
  endtask

  initial begin
    band_hi = 1280;
    band_lo = 1040;
    beta_k = 3950;
    nom_ohms = 10000;
    ser_ohms = 10000;
    acc_count = 0;
    acc_sum = 0;
    track_lo = 0;
    track_hi = 0;
    track_valid = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: faults at both ends, mid scale, near-rail groups, alternating bits
    add_group(0, 0);
    add_group(1023, 0);
    add_group(512, 0);
    for (int i = 0; i < SAMPLES; i++) pending_samples.push_back(i[0] ? 10'h155 : 10'h2AA);
    add_group(1, 0);
    add_group(1022, 0);
    random_groups(3);
    drain();

    // extremes of the band and the resistors
    set_config(8191, -8192, 6000, 1000000, 100);
    add_group(1022, 0);
    add_group(1, 0);
    random_groups(5);
    drain();
    set_config(-8192, 8191, 1000, 100, 1000000);
    random_groups(5);
    drain();
    // zero series resistor, zero nominal resistor, zero beta
    set_config(1280, 1040, 3950, 10000, 0);
    add_group(600, 5);
    random_groups(2);
    drain();
    set_config(1280, 1040, 3950, 0, 10000);
    add_group(300, 5);
    random_groups(2);
    drain();
    set_config(1280, 1040, 0, 10000, 10000);
    add_group(200, 5);
    add_group(900, 5);
    random_groups(2);
    drain();

    // random settings
    for (int p = 0; p < 4; p++) begin
      set_config($urandom_range(800, 1600), $urandom_range(600, 1400), $urandom_range(1000, 6000),
                 $urandom_range(100, 1000000), $urandom_range(100, 1000000));
      random_groups(2);
      drain();
    end

    // narrow band back at defaults, no idling on either side
    set_config(1240, 1200, 3950, 10000, 10000);
    quiet = 1'b1;
    random_groups(6);
    drain();

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // global watchdog
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
